[sv/clle_pkg.sv]
// Package for the cursor linked-list engine: request, status and sequencer
// codes, default sizes and the control bundle for the node store.
// No dependencies.
package clle_pkg;

  // Default sizes handed to the top-level parameters
  localparam int NODE_COUNT_DEF    = 128;
  localparam int ELEMENT_WIDTH_DEF = 32;

  // Fixed widths of the transaction fields
  localparam int POS_W  = 7;
  localparam int REQ_W  = 3;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  // Request codes; the unused code falls to the default arm
  typedef enum logic [REQ_W-1:0] {
    REQ_FIND      = 3'd0,
    REQ_FIND_PREV = 3'd1,
    REQ_INSERT    = 3'd2,
    REQ_DELETE    = 3'd3,
    REQ_ALLOC     = 3'd4,
    REQ_FREE      = 3'd5,
    REQ_IS_LAST   = 3'd6
  } req_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_NO_SPACE   = 2'd2,
    ST_WALK_LIMIT = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_WALK_FIRST,
    S_WALK,
    S_DEL_W1,
    S_DEL_R0,
    S_DEL_W2,
    S_DEL_W3,
    S_POP_T,
    S_POP_W0,
    S_INS_RP,
    S_INS_WT,
    S_INS_WP,
    S_ALC_WT,
    S_FREE_W1,
    S_FREE_W2,
    S_LAST_CHK,
    S_DONE
  } state_t;

  // Enables for the node store ports
  typedef struct packed {
    logic link_re;
    logic link_we;
    logic elem_re;
    logic elem_we;
  } mem_ctl_t;

endpackage

[sv/clle_store.sv]
// Node store of the linked-list engine: the link memory and the element
// memory, each with one write port and one registered read port.
// Depends on clle_pkg for the control bundle.
module clle_store import clle_pkg::*; #(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF,
  localparam int IDX_W        = $clog2(NODE_COUNT)
) (
  input  logic                     clk,
  input  mem_ctl_t                 ctl,
  input  logic [IDX_W-1:0]         rd_addr,
  input  logic [IDX_W-1:0]         link_wr_addr,
  input  logic [IDX_W-1:0]         link_wr_data,
  input  logic [IDX_W-1:0]         elem_wr_addr,
  input  logic [ELEMENT_WIDTH-1:0] elem_wr_data,
  output logic [IDX_W-1:0]         link_rd_data,
  output logic [ELEMENT_WIDTH-1:0] elem_rd_data
);

  logic [IDX_W-1:0]         link_mem [NODE_COUNT];
  logic [ELEMENT_WIDTH-1:0] elem_mem [NODE_COUNT];
  logic [IDX_W-1:0]         link_rd_r;
  logic [ELEMENT_WIDTH-1:0] elem_rd_r;

  // Link memory: write, and register the read word
  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[link_wr_addr] <= link_wr_data;
    end
    if (ctl.link_re) begin
      link_rd_r <= link_mem[rd_addr];
    end
  end

  // Element memory: write, and register the read word
  always_ff @(posedge clk) begin
    if (ctl.elem_we) begin
      elem_mem[elem_wr_addr] <= elem_wr_data;
    end
    if (ctl.elem_re) begin
      elem_rd_r <= elem_mem[rd_addr];
    end
  end

  assign link_rd_data = link_rd_r;
  assign elem_rd_data = elem_rd_r;

endmodule

[sv/cursor_linked_list_engine_top.sv]
// Top level of the cursor linked-list engine: request sequencer, walk
// compare unit and output register. Depends on clle_pkg and clle_store.
//
// Usage: one request transaction on the in_ channel (valid/ready) gives
// exactly one result transaction on the out_ channel (valid/ready).
// Node 0 heads the free list and a link of 0 means null.
// After reset a clearing pass writes the initial free-list chain into the
// link memory, one entry a cycle, with in_ready low.
// One request at a time: in_ready rises again in the cycle after a result loads.
// Each step of a walk is one link-memory read:
//   find / find previous: walk until a node matches, the list ends or
//     the walk limit trips after NODE_COUNT nodes
//   delete: as the walk, then relink the matched node on a match
//   insert pops the free list and splices; alloc pops and clears the link;
//   free pushes the node; is_last reads one link; rejected requests go to done
// The walk visits one node per cycle: each registered read of a node's
// link and element feeds the compare and the next read address.
// A finished result sits in the output register; a new request may be
// accepted while it waits, and the next result holds in the sequencer
// until out_ready frees the register.
module cursor_linked_list_engine_top import clle_pkg::*; #(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [VAL_W-1:0]  in_element_value,
  input  logic [POS_W-1:0]  in_list_head,
  input  logic [POS_W-1:0]  in_node_position,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [POS_W-1:0]  out_result_position,
  output logic [STAT_W-1:0] out_status,
  output logic              out_condition_true
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int CNT_W = IDX_W + 1;
  localparam int CW    = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;
  localparam int EXT_W = ELEMENT_WIDTH + VAL_W;

  state_t                   state_r, state_nxt;
  req_t                     req_r;
  logic [ELEMENT_WIDTH-1:0] x_r;
  logic [POS_W-1:0]         head_r, pos_r;
  logic [IDX_W-1:0]         cur_r, cur_nxt;
  logic [IDX_W-1:0]         prev_r, prev_nxt;
  logic [IDX_W-1:0]         tmp_r, tmp_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [IDX_W-1:0]         clr_r, clr_nxt;
  logic [POS_W-1:0]         res_pos_r, res_pos_nxt;
  status_t                  res_st_r, res_st_nxt;
  logic                     res_cond_r, res_cond_nxt;
  logic                     out_valid_r;
  logic [POS_W-1:0]         out_pos_r;
  status_t                  out_st_r;
  logic                     out_cond_r;
  logic                     out_load;

  // Store interface
  mem_ctl_t                 ctl;
  logic [IDX_W-1:0]         rd_addr, link_wr_addr, link_wr_data, elem_wr_addr;
  logic [IDX_W-1:0]         link_rd;
  logic [ELEMENT_WIDTH-1:0] elem_rd;

  // Width conversions between 7-bit positions and node indexes
  logic [EXT_W-1:0]         in_elem_ext;
  logic [CW-1:0]            head_w, pos_w, cur_w, prev_w;
  logic [IDX_W-1:0]         head_idx, pos_idx;
  logic                     head_ok, pos_ok, pos_zero, clr_last, in_acc;

  assign in_elem_ext = EXT_W'(in_element_value);
  assign head_w      = CW'(head_r);
  assign pos_w       = CW'(pos_r);
  assign cur_w       = CW'(cur_r);
  assign prev_w      = CW'(prev_r);
  assign head_idx    = head_w[IDX_W-1:0];
  assign pos_idx     = pos_w[IDX_W-1:0];
  assign head_ok     = head_w < CW'(NODE_COUNT);
  assign pos_ok      = pos_w < CW'(NODE_COUNT);
  assign pos_zero    = (pos_r == '0);
  assign clr_last    = (clr_r == IDX_W'(NODE_COUNT - 1));
  assign in_acc      = in_valid && in_ready;
  assign in_ready    = (state_r == S_IDLE);

  clle_store #(
    .NODE_COUNT   (NODE_COUNT),
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) u_store (
    .clk          (clk),
    .ctl          (ctl),
    .rd_addr      (rd_addr),
    .link_wr_addr (link_wr_addr),
    .link_wr_data (link_wr_data),
    .elem_wr_addr (elem_wr_addr),
    .elem_wr_data (x_r),
    .link_rd_data (link_rd),
    .elem_rd_data (elem_rd)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= req_t'(in_req_type);
      x_r    <= in_elem_ext[ELEMENT_WIDTH-1:0];
      head_r <= in_list_head;
      pos_r  <= in_node_position;
    end
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    tmp_r      <= tmp_nxt;
    cnt_r      <= cnt_nxt;
    res_pos_r  <= res_pos_nxt;
    res_st_r   <= res_st_nxt;
    res_cond_r <= res_cond_nxt;
    if (out_load) begin
      out_pos_r  <= res_pos_r;
      out_st_r   <= res_st_r;
      out_cond_r <= res_cond_r;
    end
  end

  // Sequencer: next state, store accesses and result
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    tmp_nxt      = tmp_r;
    cnt_nxt      = cnt_r;
    res_pos_nxt  = res_pos_r;
    res_st_nxt   = res_st_r;
    res_cond_nxt = res_cond_r;
    out_load     = 1'b0;
    ctl          = '0;
    rd_addr      = '0;
    link_wr_addr = '0;
    link_wr_data = '0;
    elem_wr_addr = cur_r;
    case (state_r)
      // Chain every node into the free list
      S_CLEAR: begin
        ctl.link_we  = 1'b1;
        link_wr_addr = clr_r;
        link_wr_data = clr_last ? '0 : IDX_W'(clr_r + 1'b1);
        clr_nxt      = IDX_W'(clr_r + 1'b1);
        if (clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DISPATCH;
        end
      end
      // Check arguments and issue the first read
      S_DISPATCH: begin
        res_pos_nxt  = '0;
        res_st_nxt   = ST_NOT_FOUND;
        res_cond_nxt = 1'b0;
        state_nxt    = S_DONE;
        case (req_r)
          REQ_FIND, REQ_FIND_PREV, REQ_DELETE: begin
            if (head_ok) begin
              ctl.link_re = 1'b1;
              rd_addr     = head_idx;
              state_nxt   = S_WALK_FIRST;
            end
          end
          REQ_INSERT: begin
            if (pos_ok && !pos_zero) begin
              ctl.link_re = 1'b1;
              state_nxt   = S_POP_T;
            end
          end
          REQ_ALLOC: begin
            ctl.link_re = 1'b1;
            state_nxt   = S_POP_T;
          end
          REQ_FREE: begin
            if (pos_ok && !pos_zero) begin
              ctl.link_re = 1'b1;
              state_nxt   = S_FREE_W1;
            end
          end
          REQ_IS_LAST: begin
            if (pos_ok) begin
              ctl.link_re = 1'b1;
              rd_addr     = pos_idx;
              state_nxt   = S_LAST_CHK;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      // Start the walk at the successor of the header
      S_WALK_FIRST: begin
        cur_nxt     = link_rd;
        prev_nxt    = head_idx;
        cnt_nxt     = '0;
        ctl.link_re = 1'b1;
        ctl.elem_re = 1'b1;
        rd_addr     = link_rd;
        state_nxt   = S_WALK;
      end
      // One node a cycle: limit, null, compare, else advance
      S_WALK: begin
        if (cnt_r == CNT_W'(NODE_COUNT)) begin
          res_pos_nxt = '0;
          res_st_nxt  = ST_WALK_LIMIT;
          state_nxt   = S_DONE;
        end else if (cur_r == '0) begin
          res_pos_nxt = (req_r == REQ_FIND_PREV) ? prev_w[POS_W-1:0] : '0;
          res_st_nxt  = ST_NOT_FOUND;
          state_nxt   = S_DONE;
        end else if (elem_rd == x_r) begin
          res_st_nxt = ST_OK;
          case (req_r)
            REQ_FIND: begin
              res_pos_nxt = cur_w[POS_W-1:0];
              state_nxt   = S_DONE;
            end
            REQ_DELETE: begin
              res_pos_nxt = cur_w[POS_W-1:0];
              tmp_nxt     = link_rd;
              state_nxt   = S_DEL_W1;
            end
            default: begin
              res_pos_nxt = prev_w[POS_W-1:0];
              state_nxt   = S_DONE;
            end
          endcase
        end else begin
          prev_nxt    = cur_r;
          cur_nxt     = link_rd;
          cnt_nxt     = CNT_W'(cnt_r + 1'b1);
          ctl.link_re = 1'b1;
          ctl.elem_re = 1'b1;
          rd_addr     = link_rd;
        end
      end
      // Unlink the matched node, then push it on the free list
      S_DEL_W1: begin
        ctl.link_we  = 1'b1;
        link_wr_addr = prev_r;
        link_wr_data = tmp_r;
        state_nxt    = S_DEL_R0;
      end
      S_DEL_R0: begin
        ctl.link_re = 1'b1;
        state_nxt   = S_DEL_W2;
      end
      S_DEL_W2: begin
        ctl.link_we  = 1'b1;
        link_wr_addr = cur_r;
        link_wr_data = link_rd;
        state_nxt    = S_DEL_W3;
      end
      S_DEL_W3: begin
        ctl.link_we  = 1'b1;
        link_wr_data = cur_r;
        state_nxt    = S_DONE;
      end
      // Take the head of the free list
      S_POP_T: begin
        if (link_rd == '0) begin
          res_pos_nxt = '0;
          res_st_nxt  = ST_NO_SPACE;
          state_nxt   = S_DONE;
        end else begin
          cur_nxt     = link_rd;
          ctl.link_re = 1'b1;
          rd_addr     = link_rd;
          state_nxt   = S_POP_W0;
        end
      end
      S_POP_W0: begin
        ctl.link_we  = 1'b1;
        link_wr_data = link_rd;
        res_pos_nxt  = cur_w[POS_W-1:0];
        res_st_nxt   = ST_OK;
        if (req_r == REQ_INSERT) begin
          ctl.elem_we = 1'b1;
          state_nxt   = S_INS_RP;
        end else begin
          state_nxt = S_ALC_WT;
        end
      end
      // Splice the new node in after the given node
      S_INS_RP: begin
        ctl.link_re = 1'b1;
        rd_addr     = pos_idx;
        state_nxt   = S_INS_WT;
      end
      S_INS_WT: begin
        ctl.link_we  = 1'b1;
        link_wr_addr = cur_r;
        link_wr_data = link_rd;
        state_nxt    = S_INS_WP;
      end
      S_INS_WP: begin
        ctl.link_we  = 1'b1;
        link_wr_addr = pos_idx;
        link_wr_data = cur_r;
        state_nxt    = S_DONE;
      end
      // Clear the link of an allocated node
      S_ALC_WT: begin
        ctl.link_we  = 1'b1;
        link_wr_addr = cur_r;
        state_nxt    = S_DONE;
      end
      // Push the node on the free list
      S_FREE_W1: begin
        ctl.link_we  = 1'b1;
        link_wr_addr = pos_idx;
        link_wr_data = link_rd;
        state_nxt    = S_FREE_W2;
      end
      S_FREE_W2: begin
        ctl.link_we  = 1'b1;
        link_wr_data = pos_idx;
        res_pos_nxt  = pos_r;
        res_st_nxt   = ST_OK;
        state_nxt    = S_DONE;
      end
      S_LAST_CHK: begin
        res_pos_nxt  = '0;
        res_st_nxt   = ST_OK;
        res_cond_nxt = (link_rd == '0);
        state_nxt    = S_DONE;
      end
      // Hold the result until the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_result_position = out_pos_r;
  assign out_status          = out_st_r;
  assign out_condition_true  = out_cond_r;

`ifndef SYNTHESIS
  // An accepted transaction goes straight to argument checking
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DISPATCH)
    else $error("accepted request did not reach dispatch");

  // The walk counter never passes the node count
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> cnt_r <= CNT_W'(NODE_COUNT))
    else $error("walk counter beyond node count");

  // No link read and write to the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.link_we && ctl.link_re |-> link_wr_addr != rd_addr)
    else $error("link memory read and write to one entry");

  // A walk-limit result carries a null position
  a_limit_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r == ST_WALK_LIMIT |-> out_pos_r == '0)
    else $error("walk limit with non-null position");

  // A result appears only from the done state
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done state");
`endif

endmodule

[tb/sv/tb.sv]
// Testbench for cursor_linked_list_engine_top: drives list requests, mirrors the node
// store to predict every result and compares each result transaction field by field.
// Depends on clle_pkg and the engine RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clle_pkg::*;

  localparam int NODES        = NODE_COUNT_DEF;
  localparam int RANDOM_ITEMS = 600;
  localparam int MAX_LISTS    = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = NODES + 16;
  localparam int PHASE_LEN    = 200;

  // Code left unused by the request enum
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  typedef struct packed {
    logic [POS_W-1:0] position;
    status_t          status;
    logic             cond;
  } list_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  in_req_type = '0;
  logic [VAL_W-1:0]  in_element_value = '0;
  logic [POS_W-1:0]  in_list_head = '0;
  logic [POS_W-1:0]  in_node_position = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [POS_W-1:0]  out_result_position;
  logic [STAT_W-1:0] out_status;
  logic              out_condition_true;

  // Mirror of the node store
  logic [POS_W-1:0] link_mirror [NODES];
  logic [VAL_W-1:0] value_mirror [NODES];
  bit               value_written [NODES];

  list_result_t     expected_results [$];
  logic [POS_W-1:0] list_heads [$];
  logic [VAL_W-1:0] value_pool [16];

  int fail_count   = 0;
  bit no_idle      = 1'b0;
  bit hold_results = 1'b0;
  bit growing      = 1'b1;

  cursor_linked_list_engine_top #(
    .NODE_COUNT(NODES),
    .ELEMENT_WIDTH(ELEMENT_WIDTH_DEF)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_element_value    (in_element_value),
    .in_list_head        (in_list_head),
    .in_node_position    (in_node_position),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_position (out_result_position),
    .out_status          (out_status),
    .out_condition_true  (out_condition_true)
  );

  always #4 clk = ~clk;

  function automatic int unsigned draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Walk from head to the node before the first match, or to the list tail; null if the walk limit trips
  function automatic status_t walk_to_prev(input logic [POS_W-1:0] head,
                                           input logic [VAL_W-1:0] x,
                                           output logic [POS_W-1:0] prev);
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] t;
    p = head;
    for (int i = 0; i < NODES; i++) begin
      t = link_mirror[p];
      if (t == '0) begin
        prev = p;
        return ST_NOT_FOUND;
      end
      if (value_mirror[t] == x) begin
        prev = p;
        return ST_OK;
      end
      p = t;
    end
    prev = '0;
    return ST_WALK_LIMIT;
  endfunction

  // Apply one request to the mirror and return the result it should give
  function automatic list_result_t apply_request(input logic [REQ_W-1:0] req,
                                                 input logic [VAL_W-1:0] x,
                                                 input logic [POS_W-1:0] head,
                                                 input logic [POS_W-1:0] pos);
    list_result_t     r;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] t;
    status_t          st;
    bit               head_ok;
    bit               pos_ok;
    r.position = '0;
    r.status   = ST_NOT_FOUND;
    r.cond     = 1'b0;
    head_ok    = int'(head) < NODES;
    pos_ok     = int'(pos) < NODES;
    case (req)
      REQ_FIND: begin
        if (head_ok) begin
          p  = link_mirror[head];
          st = ST_WALK_LIMIT;
          for (int i = 0; i < NODES; i++) begin
            if (p == '0) begin
              st = ST_NOT_FOUND;
              break;
            end
            if (value_mirror[p] == x) begin
              st = ST_OK;
              break;
            end
            p = link_mirror[p];
          end
          r.status   = st;
          r.position = (st == ST_OK) ? p : '0;
        end
      end
      REQ_FIND_PREV: begin
        if (head_ok) begin
          r.status   = walk_to_prev(head, x, p);
          r.position = p;
        end
      end
      REQ_INSERT: begin
        if (pos_ok && pos != '0) begin
          t = link_mirror[0];
          if (t == '0) begin
            r.status = ST_NO_SPACE;
          end else begin
            link_mirror[0]   = link_mirror[t];
            value_mirror[t]  = x;
            value_written[t] = 1'b1;
            link_mirror[t]   = link_mirror[pos];
            link_mirror[pos] = t;
            r.position       = t;
            r.status         = ST_OK;
          end
        end
      end
      REQ_DELETE: begin
        if (head_ok) begin
          st       = walk_to_prev(head, x, p);
          r.status = st;
          if (st == ST_OK) begin
            t              = link_mirror[p];
            link_mirror[p] = link_mirror[t];
            link_mirror[t] = link_mirror[0];
            link_mirror[0] = t;
            r.position     = t;
          end
        end
      end
      REQ_ALLOC: begin
        t = link_mirror[0];
        if (t == '0) begin
          r.status = ST_NO_SPACE;
        end else begin
          link_mirror[0] = link_mirror[t];
          link_mirror[t] = '0;
          r.position     = t;
          r.status       = ST_OK;
        end
      end
      REQ_FREE: begin
        if (pos_ok && pos != '0) begin
          link_mirror[pos] = link_mirror[0];
          link_mirror[0]   = pos;
          r.position       = pos;
          r.status         = ST_OK;
        end
      end
      REQ_IS_LAST: begin
        if (pos_ok) begin
          r.status = ST_OK;
          r.cond   = (link_mirror[pos] == '0);
        end
      end
      default: begin
        r.status = ST_NOT_FOUND;
      end
    endcase
    return r;
  endfunction

  // Offer one request after a random gap; predict its result once accepted
  task automatic send_req(input logic [REQ_W-1:0] req, input logic [VAL_W-1:0] x,
                          input logic [POS_W-1:0] head, input logic [POS_W-1:0] pos,
                          output list_result_t res);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_element_value <= x;
    in_list_head     <= head;
    in_node_position <= pos;
    do @(posedge clk); while (!in_ready);
    res = apply_request(req, x, head, pos);
    expected_results.push_back(res);
    @(negedge clk);
  endtask

  // Build one request: mostly operations on tracked lists, some raw noise
  task automatic send_random_item();
    logic [REQ_W-1:0] req;
    logic [VAL_W-1:0] x;
    logic [POS_W-1:0] head;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] p;
    list_result_t     res;
    int unsigned      roll;
    int unsigned      steps;
    int               idx;
    bit               wellformed;
    bit               safe;
    roll       = $urandom_range(0, 99);
    x          = ($urandom_range(0, 4) != 0) ? value_pool[$urandom_range(0, 15)] : $urandom;
    head       = '0;
    pos        = '0;
    idx        = 0;
    wellformed = 1'b0;
    if (roll < 10) begin
      req  = REQ_W'($urandom_range(0, 7));
      x    = $urandom;
      head = POS_W'($urandom_range(0, NODES - 1));
      pos  = POS_W'($urandom_range(0, NODES - 1));
      if ((req == REQ_INSERT || req == REQ_FREE) && $urandom_range(0, 3) != 0) pos = '0;
    end else if (list_heads.size() == 0) begin
      req        = REQ_ALLOC;
      wellformed = 1'b1;
    end else begin
      wellformed = 1'b1;
      idx        = $urandom_range(0, list_heads.size() - 1);
      head       = list_heads[idx];
      // pick a node up to six steps down the list
      p     = head;
      steps = $urandom_range(0, 6);
      repeat (steps) if (link_mirror[p] != '0) p = link_mirror[p];
      pos  = p;
      roll = $urandom_range(0, 99);
      if (growing) begin
        if (roll < 8 && (list_heads.size() < MAX_LISTS || link_mirror[0] == '0)) begin
          req = REQ_ALLOC;
        end else if (roll < 70) begin
          req = REQ_INSERT;
        end else if (roll < 80) begin
          req = REQ_FIND;
        end else if (roll < 87) begin
          req = REQ_FIND_PREV;
        end else if (roll < 93) begin
          req = REQ_IS_LAST;
        end else begin
          req = REQ_DELETE;
        end
      end else begin
        if (roll < 45) begin
          req = REQ_DELETE;
        end else if (roll < 60) begin
          req = REQ_FIND;
        end else if (roll < 70) begin
          req = REQ_FIND_PREV;
        end else if (roll < 78) begin
          req = REQ_IS_LAST;
        end else if (roll < 92) begin
          req = (link_mirror[head] == '0) ? REQ_FREE : REQ_DELETE;
        end else begin
          req = REQ_INSERT;
        end
      end
      if (req == REQ_FREE) pos = head;
    end
    // Keep walks off nodes whose element was never written
    if (req == REQ_FIND || req == REQ_FIND_PREV || req == REQ_DELETE) begin
      safe = 1'b1;
      p    = link_mirror[head];
      for (int i = 0; i < NODES && p != '0; i++) begin
        if (!value_written[p]) begin
          safe = 1'b0;
          break;
        end
        if (value_mirror[p] == x) break;
        p = link_mirror[p];
      end
      if (!safe) begin
        req = REQ_IS_LAST;
        pos = head;
      end
    end
    send_req(req, x, head, pos, res);
    // Track list headers
    if (wellformed && req == REQ_ALLOC && res.status == ST_OK) list_heads.push_back(res.position);
    if (wellformed && req == REQ_FREE) list_heads.delete(idx);
  endtask

  // Searches, an is_last check, a delete and a free on a freshly allocated, empty list
  task automatic test_empty_list();
    list_result_t     res;
    logic [POS_W-1:0] hd;
    send_req(REQ_ALLOC, '0, '0, '0, res);
    hd = res.position;
    send_req(REQ_FIND, 32'h0000_0001, hd, '0, res);
    send_req(REQ_FIND_PREV, 32'h0000_0001, hd, '0, res);
    send_req(REQ_IS_LAST, '0, '0, hd, res);
    send_req(REQ_DELETE, 32'h0000_0001, hd, '0, res);
    send_req(REQ_FREE, '0, '0, hd, res);
  endtask

  // Build a short list with extreme values, then search and delete in it
  task automatic test_insert_and_search();
    list_result_t     res;
    logic [POS_W-1:0] hd;
    logic [POS_W-1:0] node_a;
    logic [POS_W-1:0] node_b;
    send_req(REQ_ALLOC, '0, '0, '0, res);
    hd = res.position;
    send_req(REQ_INSERT, 32'h0000_0000, '0, hd, res);
    node_a = res.position;
    send_req(REQ_INSERT, 32'hFFFF_FFFF, '0, node_a, res);
    node_b = res.position;
    send_req(REQ_INSERT, 32'h5A5A_A5A5, '0, hd, res);
    send_req(REQ_FIND, 32'hFFFF_FFFF, hd, '0, res);
    send_req(REQ_FIND_PREV, 32'h0000_0000, hd, '0, res);
    // no match: previous is the tail
    send_req(REQ_FIND_PREV, 32'h1234_5678, hd, '0, res);
    send_req(REQ_IS_LAST, '0, '0, node_b, res);
    send_req(REQ_DELETE, 32'h0000_0000, hd, '0, res);
    send_req(REQ_DELETE, 32'h1234_5678, hd, '0, res);
    list_heads.push_back(hd);
  endtask

  // Node zero as a target and the unused request code
  task automatic test_rejected_requests();
    list_result_t res;
    send_req(REQ_INSERT, 32'hDEAD_BEEF, '0, '0, res);
    send_req(REQ_FREE, '0, '0, '0, res);
    send_req(REQ_UNUSED, $urandom, 7'h7F, 7'h7F, res);
    send_req(REQ_IS_LAST, '0, '0, '0, res);
  endtask

  // Free a listed node, then insert after it: the node links to itself
  task automatic test_walk_limit();
    list_result_t     res;
    logic [POS_W-1:0] hd;
    logic [POS_W-1:0] node_a;
    logic [VAL_W-1:0] v;
    v = $urandom;
    send_req(REQ_ALLOC, '0, '0, '0, res);
    hd = res.position;
    send_req(REQ_INSERT, v, '0, hd, res);
    node_a = res.position;
    send_req(REQ_FREE, '0, '0, node_a, res);
    send_req(REQ_INSERT, v, '0, node_a, res);
    send_req(REQ_FIND, ~v, hd, '0, res);
    send_req(REQ_FIND_PREV, ~v, hd, '0, res);
    send_req(REQ_DELETE, ~v, hd, '0, res);
    send_req(REQ_FIND, v, hd, '0, res);
  endtask

  // Hold the result side for a long stretch while requests keep coming
  task automatic test_backpressure();
    hold_results = 1'b1;
    no_idle      = 1'b1;
    repeat (12) send_random_item();
    no_idle = 1'b0;
  endtask

  // Alternate growth and shrink phases, with stretches of no idling
  task automatic test_random_traffic();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      growing = ((n / PHASE_LEN) % 2) == 0;
      if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send_random_item();
    end
    no_idle = 1'b0;
  endtask

  // Result side ready, with random stalls and one long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    @(negedge clk);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        gap          = HOLD_CYCLES;
      end else begin
        gap = draw_gap();
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: result_position %0d, status %0d, condition_true %0d",
               out_result_position, out_status, out_condition_true);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_result_position !== want.position) begin
          $error("result_position: expected %0d, actual %0d", want.position, out_result_position);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          fail_count++;
        end
        if (out_condition_true !== want.cond) begin
          $error("condition_true: expected %0d, actual %0d", want.cond, out_condition_true);
          fail_count++;
        end
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : run_tests
    // Mirror the reset state: the free list chains every node
    for (int i = 0; i < NODES; i++) begin
      link_mirror[i]   = (i + 1 < NODES) ? POS_W'(i + 1) : '0;
      value_mirror[i]  = '0;
      value_written[i] = 1'b0;
    end
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 16; i++) value_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_insert_and_search();
    test_rejected_requests();
    test_walk_limit();
    test_backpressure();
    test_random_traffic();

    // Drain outstanding results, then allow for a stray late result
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
